### design/shamh_pkg.sv
// Shared types, constants and round functions for the SHA-256 message hasher.
`default_nettype none

package shamh_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } result_t;

    // Controls from the sequencer to the round unit
    typedef struct packed {
        logic       load;      // working words <= chaining words
        logic       round_en;  // one compression round
        logic       add;       // chaining words += working words
        logic       init;      // chaining words <= initial values
        logic [5:0] round;
    } rnd_ctrl_t;

    // Controls from the sequencer to the block buffer / schedule
    typedef struct packed {
        logic       wr_en;
        logic [5:0] wr_pos;
        logic [7:0] wr_byte;
        logic       shift_en;
    } sched_ctrl_t;

    localparam int unsigned NUM_WORDS  = 8;
    localparam int unsigned BLK_WORDS  = 16;
    localparam logic [7:0]  PAD_MARK   = 8'h80;
    localparam logic [5:0]  LEN_POS    = 6'd56;
    localparam logic [5:0]  LAST_POS   = 6'd63;
    localparam logic [5:0]  LAST_ROUND = 6'd63;
    localparam logic [2:0]  LAST_IDX   = 3'd7;

    localparam logic [NUM_WORDS-1:0][31:0] INIT_H = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        unique case (t)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

### design/shamh_sched.sv
// Block buffer held as sixteen words that shift to form the message schedule.
`default_nettype none

module shamh_sched
    import shamh_pkg::*;
(
    input  wire logic        clk,
    input  wire sched_ctrl_t ctrl,
    output logic [31:0]      w_cur
);

    logic [BLK_WORDS-1:0][31:0] w_reg;
    logic [31:0]                w_new;

    // W[t+16] from the sixteen-word window
    assign w_new = w_reg[0] + small_sig0(w_reg[1]) + w_reg[9] + small_sig1(w_reg[14]);
    assign w_cur = w_reg[0];

    always_ff @(posedge clk)
    begin
        if (ctrl.shift_en)
        begin
            for (int i = 0; i < BLK_WORDS - 1; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[BLK_WORDS-1] <= w_new;
        end
        else if (ctrl.wr_en)
        begin
            // big-endian: byte 0 of a word lands in the top lane
            w_reg[ctrl.wr_pos[5:2]][{~ctrl.wr_pos[1:0], 3'b000} +: 8] <= ctrl.wr_byte;
        end
    end

endmodule

`default_nettype wire

### design/shamh_round.sv
// Shared compression round unit with working and chaining words.
`default_nettype none

module shamh_round
    import shamh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire rnd_ctrl_t   ctrl,
    input  wire logic [31:0] w_cur,
    input  wire logic [2:0]  rd_idx,
    output logic [31:0]      rd_word
);

    logic [NUM_WORDS-1:0][31:0] chain_reg;
    logic [NUM_WORDS-1:0][31:0] v_reg;
    logic [31:0] t1, t2, choose, major;

    assign choose = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign major  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1     = v_reg[7] + big_sig1(v_reg[4]) + choose + round_k(ctrl.round) + w_cur;
    assign t2     = big_sig0(v_reg[0]) + major;

    assign rd_word = chain_reg[rd_idx];

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            v_reg <= chain_reg;
        end
        else if (ctrl.round_en)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= INIT_H;
        end
        else if (ctrl.init)
        begin
            chain_reg <= INIT_H;
        end
        else if (ctrl.add)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                chain_reg[i] <= chain_reg[i] + v_reg[i];
            end
        end
    end

endmodule

`default_nettype wire

### design/sha256_message_hasher_top.sv
// Top level of the SHA-256 message hasher: sequencer, padding and digest output.
//
//  channel   signals                          payload
//  item      item_valid / item_ready / item   item_t   (one byte, flag, close)
//  result    result_valid / result_ready      result_t (one digest word)
//
// A byte is taken while the hasher is idle. Filling a block runs the compression
// rounds and then the add on the single shared round unit. A close writes the
// padding one byte per cycle up to byte 63 (a second block when the message ends
// at byte 55 or later of a block), compresses each padding block, and offers 8
// words. item_ready is low while a block is compressed, and after a close until
// the last word is transferred.
// Reset returns the chaining words to the initial values and the count to zero.
`default_nettype none

module sha256_message_hasher_top
    import shamh_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic item_valid,
    output logic      item_ready,
    input  wire item_t item,
    output logic      result_valid,
    input  wire logic result_ready,
    output result_t   result
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PAD  = 5'b00010,
        S_COMP = 5'b00100,
        S_ADD  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [60:0] count_reg, count_next;
    logic [5:0]  ptr_reg, ptr_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  widx_reg, widx_next;
    logic        close_reg, close_next;     // digest due after this block
    logic        first_reg, first_next;     // 0x80 still to be written
    logic        final_reg, final_next;     // padding block carries the length
    logic        done_reg, done_next;       // length block compressed

    logic [60:0] count_inc;
    logic [5:0]  fill_after;
    logic [63:0] len_bits;
    logic [7:0]  pad_byte;
    logic        in_xfer, out_xfer;
    logic [31:0] w_cur, rd_word;
    rnd_ctrl_t   rctl;
    sched_ctrl_t sctl;

    assign in_xfer    = item_valid && item_ready;
    assign out_xfer   = result_valid && result_ready;
    assign count_inc  = count_reg + 61'd1;
    assign fill_after = item.has_byte ? count_inc[5:0] : count_reg[5:0];
    assign len_bits   = {count_reg, 3'b000};

    always_comb
    begin
        priority if (first_reg)
            pad_byte = PAD_MARK;
        else if (final_reg && ptr_reg >= LEN_POS)
            pad_byte = len_bits[{3'd7 - ptr_reg[2:0], 3'b000} +: 8];
        else
            pad_byte = 8'h00;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        rnd_next   = rnd_reg;
        widx_next  = widx_reg;
        close_next = close_reg;
        first_next = first_reg;
        final_next = final_reg;
        done_next  = done_reg;

        item_ready   = 1'b0;
        result_valid = 1'b0;
        rctl         = '0;
        rctl.round   = rnd_reg;
        sctl         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (in_xfer)
                begin
                    if (item.has_byte)
                    begin
                        sctl.wr_en   = 1'b1;
                        sctl.wr_pos  = count_reg[5:0];
                        sctl.wr_byte = item.data_byte;
                        count_next   = count_inc;
                    end
                    if (item.end_of_message)
                    begin
                        close_next = 1'b1;
                        first_next = 1'b1;
                        done_next  = 1'b0;
                    end
                    if (item.has_byte && count_reg[5:0] == LAST_POS)
                    begin
                        state_next = S_COMP;
                        rctl.load  = 1'b1;
                        rnd_next   = '0;
                    end
                    else if (item.end_of_message)
                    begin
                        state_next = S_PAD;
                        ptr_next   = fill_after;
                        final_next = fill_after < LEN_POS;
                    end
                end
            end
            S_PAD:
            begin
                sctl.wr_en   = 1'b1;
                sctl.wr_pos  = ptr_reg;
                sctl.wr_byte = pad_byte;
                first_next   = 1'b0;
                ptr_next     = ptr_reg + 6'd1;
                if (ptr_reg == LAST_POS)
                begin
                    state_next = S_COMP;
                    rctl.load  = 1'b1;
                    rnd_next   = '0;
                    done_next  = final_reg;
                end
            end
            S_COMP:
            begin
                rctl.round_en = 1'b1;
                sctl.shift_en = 1'b1;
                rnd_next      = rnd_reg + 6'd1;
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                rctl.add = 1'b1;
                priority if (close_reg && done_reg)
                begin
                    state_next = S_OUT;
                    widx_next  = '0;
                end
                else if (close_reg)
                begin
                    // tail spilled over, or block filled by the closing byte
                    state_next = S_PAD;
                    ptr_next   = '0;
                    final_next = 1'b1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                result_valid = 1'b1;
                if (out_xfer)
                begin
                    widx_next = widx_reg + 3'd1;
                    if (widx_reg == LAST_IDX)
                    begin
                        state_next = S_IDLE;
                        rctl.init  = 1'b1;
                        count_next = '0;
                        close_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            rnd_reg   <= '0;
            widx_reg  <= '0;
            close_reg <= 1'b0;
            first_reg <= 1'b0;
            final_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            rnd_reg   <= rnd_next;
            widx_reg  <= widx_next;
            close_reg <= close_next;
            first_reg <= first_next;
            final_reg <= final_next;
            done_reg  <= done_next;
        end
    end

    shamh_sched u_sched (
        .clk   (clk),
        .ctrl  (sctl),
        .w_cur (w_cur)
    );

    shamh_round u_round (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (rctl),
        .w_cur   (w_cur),
        .rd_idx  (widx_reg),
        .rd_word (rd_word)
    );

    assign result.digest_word = rd_word;
    assign result.word_index  = widx_reg;
    assign result.last_word   = (widx_reg == LAST_IDX);

    // input and output sides never open together
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(item_ready && result_valid))
        else $error("item_ready and result_valid high together");

    // last digest word hands back to the input side
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && result.last_word |=> item_ready)
        else $error("not idle after last digest word");

    // an empty item without close changes nothing
    a_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && !item.has_byte && !item.end_of_message
        |=> item_ready && $stable(count_reg))
        else $error("empty item disturbed the hasher");

    // a closing transfer leads to the padding or a compression
    a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.end_of_message |=> !item_ready)
        else $error("close transfer did not start the finish");

endmodule

`default_nettype wire

### bench/sha256_message_hasher_top_test.sv
// Self-checking bench for the SHA-256 message hasher: random byte streams vs a digest predictor.
`timescale 1ns / 100ps

module sha256_message_hasher_top_test
    import shamh_pkg::*;
;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned SETTLE_TAIL  = 100;
    localparam int unsigned RANDOM_ITEMS = 280;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam logic [7:0]  PAD_BYTE     = 8'h80;

    localparam logic [0:7][31:0] IV_WORDS = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] ROUND_CONST = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_PATTERN} rx_mode_t;

    typedef struct packed {
        item_t it;
        logic  drain_first;   // hold this transfer until all digest words are back
    } feed_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_ready;
    item_t   item = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    sha256_message_hasher_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // predictor state
    logic [31:0] chain_h [0:7];
    logic [7:0]  msg_block [0:63];
    logic [60:0] byte_total;

    feed_t       byte_feed [$];
    result_t     digests_due [$];

    int          feed_count = 0;
    int          taken_items = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    // sender
    logic        offer;
    feed_t       head_feed;
    int          burst_left = 1;
    int          gap_left = 0;

    // receiver
    logic        take;
    rx_mode_t    stall_mode = RX_ALWAYS;
    int          mode_left = 0;
    logic [7:0]  stall_pattern = 8'h5a;
    int          hold_left = 0;
    logic        hold_used = 1'b0;
    result_t     want;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic sha_restart();
        int i;
        for (i = 0; i < 8; i++)
            chain_h[i] = IV_WORDS[i];
        byte_total = '0;
    endtask

    task automatic sha_fold_block();
        logic [31:0] w [0:63];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        int i;
        for (i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (i = 16; i < 64; i++)
            w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
        e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
        for (i = 0; i < 64; i++)
        begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_CONST[i] + w[i];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endtask

    // one accepted transfer: absorb the byte, and on a close pad and queue the digest
    task automatic sha_absorb(input item_t it);
        int          fill;
        int          i;
        logic [63:0] bits;
        result_t     r;
        if (it.has_byte)
        begin
            fill = int'(byte_total[5:0]);
            msg_block[fill] = it.data_byte;
            byte_total = byte_total + 61'd1;
            if (fill == 63)
                sha_fold_block();
        end
        if (it.end_of_message)
        begin
            bits = {byte_total, 3'b000};
            fill = int'(byte_total[5:0]);
            msg_block[fill] = PAD_BYTE;
            fill = fill + 1;
            // no room for the length: spill into an extra block
            if (fill > 56)
            begin
                while (fill < 64)
                begin
                    msg_block[fill] = 8'h00;
                    fill = fill + 1;
                end
                sha_fold_block();
                fill = 0;
            end
            while (fill < 56)
            begin
                msg_block[fill] = 8'h00;
                fill = fill + 1;
            end
            for (i = 0; i < 8; i++)
                msg_block[56 + i] = bits[63 - 8*i -: 8];
            sha_fold_block();
            for (i = 0; i < 8; i++)
            begin
                r.digest_word = chain_h[i];
                r.word_index  = i[2:0];
                r.last_word   = (i == 7);
                digests_due.push_back(r);
            end
            sha_restart();
        end
    endtask

    task automatic queue_item(input logic [7:0] data, input logic has, input logic close,
                              input logic drain);
        feed_t fd;
        fd.it.data_byte      = data;
        fd.it.has_byte       = has;
        fd.it.end_of_message = close;
        fd.drain_first       = drain;
        byte_feed.push_back(fd);
        if (has || close)
            feed_count++;
    endtask

    // random message body; the close either rides on the last byte or follows on its own
    task automatic queue_message(input int len, input logic close_on_byte, input logic drain);
        int k;
        for (k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
            queue_item(8'($urandom_range(0, 255)), 1'b1, close_on_byte && (k == len - 1),
                       drain && (k == 0));
        end
        if (!close_on_byte || len == 0)
            queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, drain && (len == 0));
    endtask

    task automatic check_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t: %s expected %h got %h", $time, what, exp_v, got_v);
            mismatches++;
        end
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            offer = item_valid;
            if (item_valid && item_ready)
            begin
                sha_absorb(item);
                taken_items++;
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (gap_left != 0)
                    gap_left--;
                else if (byte_feed.size() != 0)
                begin
                    head_feed = byte_feed[0];
                    if (!(head_feed.drain_first && digests_due.size() != 0))
                    begin
                        head_feed = byte_feed.pop_front();
                        item <= head_feed.it;
                        offer = 1'b1;
                        if (burst_left > 1)
                            burst_left--;
                        else
                        begin
                            burst_left = $urandom_range(1, 24);
                            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                        end
                    end
                end
            end
            item_valid <= offer;
        end
    end

    // long receiver hold-off once a digest is pending, so the input backs up
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (rst_n && !hold_used && taken_items >= 60 && digests_due.size() != 0)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // monitor and receiver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (digests_due.size() == 0)
                begin
                    $display("%0t: digest word expected none got %h", $time,
                             result.digest_word);
                    mismatches++;
                end
                else
                begin
                    want = digests_due.pop_front();
                    check_field("digest_word", want.digest_word, result.digest_word);
                    check_field("word_index", 32'(want.word_index), 32'(result.word_index));
                    check_field("last_word", 32'(want.last_word), 32'(result.last_word));
                end
            end
            if (mode_left == 0)
            begin
                stall_mode = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 200);
                stall_pattern = 8'($urandom_range(1, 255));
            end
            else
                mode_left--;
            stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
            if (hold_left != 0)
                take = 1'b0;
            else
            begin
                unique case (stall_mode)
                    RX_ALWAYS: take = 1'b1;
                    RX_COIN:   take = 1'($urandom_range(0, 1));
                    default:   take = stall_pattern[0];
                endcase
            end
            result_ready <= take;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int len;
        sha_restart();

        // empty messages, one with stray data on the close
        queue_item(8'h00, 1'b0, 1'b1, 1'b0);
        queue_item(8'hff, 1'b0, 1'b1, 1'b1);
        // single byte closed on the same transfer, both extremes
        queue_item(8'h00, 1'b1, 1'b1, 1'b0);
        queue_item(8'hff, 1'b1, 1'b1, 1'b0);
        // "abc" with idle transfers mixed in, closed on its own
        queue_item(8'h61, 1'b1, 1'b0, 1'b0);
        queue_item(8'hff, 1'b0, 1'b0, 1'b0);
        queue_item(8'h62, 1'b1, 1'b0, 1'b0);
        queue_item(8'h00, 1'b0, 1'b0, 1'b0);
        queue_item(8'h63, 1'b1, 1'b0, 1'b0);
        queue_item(8'h5a, 1'b0, 1'b1, 1'b1);
        queue_item(8'ha5, 1'b1, 1'b0, 1'b0);
        queue_item(8'h5a, 1'b1, 1'b1, 1'b0);

        // padding spill and a block completed just before the close
        queue_message(56, 1'b1, 1'b1);
        queue_message(64, 1'b0, 1'b0);
        while (feed_count < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 5))
                    0: len = 55;
                    1: len = 56;
                    2: len = 57;
                    3: len = 63;
                    4: len = 64;
                    default: len = 65;
                endcase
            end
            else
                len = $urandom_range(0, 24);
            queue_message(len, 1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_feed.size() != 0 || item_valid)
            @(posedge clk);
        while (digests_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TAIL) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
design/shamh_pkg.sv
design/shamh_sched.sv
design/shamh_round.sv
design/sha256_message_hasher_top.sv
bench/sha256_message_hasher_top_test.sv
